### rtl/core/fprx_pkg.sv
// Shared types, constants and the CRC byte update for the frame receiver.
package fprx_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;
  localparam int HDR_BYTES       = 9;
  localparam int CRC_BYTES       = 2;
  localparam int CMP_W           = 18;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 11;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  SYNC0_DEF = 8'd79;
  localparam logic [7:0]  SYNC1_DEF = 8'd84;
  localparam logic [7:0]  SYNC2_DEF = 8'd65;
  localparam logic [7:0]  SYNC3_DEF = 8'd49;
  localparam logic [10:0] LIMIT_DEF = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_HUNT   = 3'd0;
  localparam logic [2:0] ST_TAKEN  = 3'd1;
  localparam logic [2:0] ST_GOOD   = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_LENERR = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] byte_pos;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] seq_num;
    logic [10:0] payload_len;
    logic [10:0] frame_length;
  } fprx_result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/fprx_core.sv
// Deframer state, configuration registers and per-word result logic.
module fprx_core #(
  parameter int MAX_PAYLOAD = fprx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [7:0]                          rx_byte,
  input  logic                                cfg_we,
  input  logic [fprx_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [fprx_pkg::CFG_DATA_W-1:0]     cfg_data,
  output fprx_pkg::fprx_result_t              res
);

  localparam int CNT_W     = $clog2(MAX_PAYLOAD + fprx_pkg::HDR_BYTES + fprx_pkg::CRC_BYTES + 1);
  localparam int FRAME_MAX = fprx_pkg::HDR_BYTES + MAX_PAYLOAD + fprx_pkg::CRC_BYTES;
  localparam int CW        = fprx_pkg::CMP_W;

  localparam logic [CNT_W-1:0] POS_TYPE   = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_SEQ_LO = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_SEQ_HI = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(8);

  logic [7:0]       sync_r [4];
  logic [10:0]      limit_r;

  logic             in_sync_r, in_sync_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  logic             clr;
  logic [15:0]      new_len;
  logic [CW-1:0]    lim;
  logic [15:0]      crc_upd;

  assign crc_upd = fprx_pkg::crc16_byte(crc_r, rx_byte);
  assign new_len = {rx_byte, len_r[7:0]};
  assign lim = (CW'(limit_r) > CW'(MAX_PAYLOAD)) ? CW'(MAX_PAYLOAD) : CW'(limit_r);

  always_comb begin
    in_sync_nxt = in_sync_r;
    cnt_nxt     = cnt_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    clr         = 1'b0;
    res           = '0;
    res.status    = fprx_pkg::ST_HUNT;
    res.data_byte = rx_byte;

    if (!in_sync_r) begin
      if (CW'(cnt_r) < CW'(4) && rx_byte == sync_r[cnt_r[1:0]]) begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[1:0] == 2'd3) begin
          in_sync_nxt = 1'b1;
        end
      end else begin
        // drop back to hunting; this word is not rechecked
        cnt_nxt = '0;
        crc_nxt = fprx_pkg::CRC_INIT;
      end
    end else if (CW'(cnt_r) >= CW'(FRAME_MAX)) begin
      clr        = 1'b1;
      res.status = fprx_pkg::ST_LENERR;
    end else begin
      cnt_nxt      = cnt_r + CNT_W'(1);
      res.status   = fprx_pkg::ST_TAKEN;
      res.byte_pos = 11'(cnt_r);
      if (cnt_r == POS_TYPE) begin
        type_nxt = rx_byte;
      end
      if (cnt_r == POS_SEQ_LO) begin
        seq_nxt[7:0] = rx_byte;
      end
      if (cnt_r == POS_SEQ_HI) begin
        seq_nxt[15:8] = rx_byte;
      end
      if (cnt_r == POS_LEN_LO) begin
        len_nxt[7:0] = rx_byte;
      end

      if (cnt_r == POS_LEN_HI) begin
        if (CW'(new_len) > lim) begin
          clr          = 1'b1;
          res.status   = fprx_pkg::ST_LENERR;
          res.byte_pos = '0;
        end else begin
          crc_nxt = crc_upd;
          len_nxt = new_len;
        end
      end else if (CW'(cnt_r) < CW'(fprx_pkg::HDR_BYTES)) begin
        crc_nxt = crc_upd;
      end else if (CW'(cnt_r) == CW'(len_r) + CW'(fprx_pkg::HDR_BYTES + 1)) begin
        // last CRC word: compare and report the frame
        res.status       = ({rx_byte, crc_lo_r} == crc_r) ? fprx_pkg::ST_GOOD
                                                          : fprx_pkg::ST_BAD;
        res.frame_type   = type_r;
        res.seq_num      = seq_r;
        res.payload_len  = 11'(len_r);
        res.frame_length = 11'(cnt_nxt);
        clr              = 1'b1;
      end else if (CW'(cnt_r) < CW'(len_r) + CW'(fprx_pkg::HDR_BYTES)) begin
        crc_nxt = crc_upd;
      end else begin
        crc_lo_nxt = rx_byte;
      end
    end

    if (clr) begin
      in_sync_nxt = 1'b0;
      cnt_nxt     = '0;
      type_nxt    = '0;
      seq_nxt     = '0;
      len_nxt     = '0;
      crc_nxt     = fprx_pkg::CRC_INIT;
      crc_lo_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r[0] <= fprx_pkg::SYNC0_DEF;
      sync_r[1] <= fprx_pkg::SYNC1_DEF;
      sync_r[2] <= fprx_pkg::SYNC2_DEF;
      sync_r[3] <= fprx_pkg::SYNC3_DEF;
      limit_r   <= fprx_pkg::LIMIT_DEF;
    end else if (cfg_we) begin
      case (cfg_idx)
        fprx_pkg::CFG_SYNC0: sync_r[0] <= cfg_data[7:0];
        fprx_pkg::CFG_SYNC1: sync_r[1] <= cfg_data[7:0];
        fprx_pkg::CFG_SYNC2: sync_r[2] <= cfg_data[7:0];
        fprx_pkg::CFG_SYNC3: sync_r[3] <= cfg_data[7:0];
        fprx_pkg::CFG_LIMIT: limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sync_r <= 1'b0;
      cnt_r     <= '0;
      type_r    <= '0;
      seq_r     <= '0;
      len_r     <= '0;
      crc_r     <= fprx_pkg::CRC_INIT;
      crc_lo_r  <= '0;
    end else if (push) begin
      in_sync_r <= in_sync_nxt;
      cnt_r     <= cnt_nxt;
      type_r    <= type_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

  a_sync_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_sync_r |-> CW'(cnt_r) >= CW'(4))
    else $error("in sync with fewer than four words counted");

  a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_sync_r |-> CW'(cnt_r) < CW'(4))
    else $error("hunting with count past the sync word");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && (res.status == fprx_pkg::ST_GOOD || res.status == fprx_pkg::ST_BAD
             || res.status == fprx_pkg::ST_LENERR)
    |=> !in_sync_r && cnt_r == '0 && crc_r == fprx_pkg::CRC_INIT)
    else $error("frame state not cleared after frame end or drop");

endmodule

### rtl/core/fprx_obuf.sv
// Two-entry output buffer (result register plus skid) for result words.
module fprx_obuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  fprx_pkg::fprx_result_t  res_in,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output fprx_pkg::fprx_result_t  res_out
);

  logic                   out_valid_r;
  logic                   skid_valid_r;
  fprx_pkg::fprx_result_t out_r;
  fprx_pkg::fprx_result_t skid_r;
  logic                   pop;

  assign pop       = out_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign res_out   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push && out_valid_r && !pop) begin
      skid_valid_r <= 1'b1;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: advance skid into the result register, or load a new word
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push && out_valid_r && !pop) begin
      skid_r <= res_in;
    end else if (push) begin
      out_r <= res_in;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while the result register is empty");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ready |=> skid_valid_r && $stable(skid_r))
    else $error("skid word lost while output stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result word changed while output stalled");

endmodule

### rtl/core/framed_packet_receiver_crc16.sv
// Top level: length-prefixed frame receiver with CRC-16/CCITT-FALSE check.
// A result word is registered in the output buffer when its input word is accepted.
// Throughput: one input word per cycle; a two-entry output buffer keeps input
// open while one result waits, so in_ready drops only with two results pending.
// Reset (rst_n low at a clock edge): frame state returns to hunting, sync bytes
// to 79/84/65/49, payload limit to 1024, output buffer empties.
module framed_packet_receiver_crc16 #(
  parameter int MAX_PAYLOAD = fprx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [10:0]                     out_byte_pos,
  output logic [7:0]                      out_data_byte,
  output logic [7:0]                      out_frame_type,
  output logic [15:0]                     out_seq_num,
  output logic [10:0]                     out_payload_len,
  output logic [10:0]                     out_frame_length,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fprx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fprx_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fprx_pkg::fprx_result_t res;
  fprx_pkg::fprx_result_t res_q;
  logic                   push;

  assign push      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  fprx_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .rx_byte  (in_rx_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_wdata),
    .res      (res)
  );

  fprx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_in    (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_status       = res_q.status;
  assign out_byte_pos     = res_q.byte_pos;
  assign out_data_byte    = res_q.data_byte;
  assign out_frame_type   = res_q.frame_type;
  assign out_seq_num      = res_q.seq_num;
  assign out_payload_len  = res_q.payload_len;
  assign out_frame_length = res_q.frame_length;

endmodule
